// ===== design/hfle_pkg.sv =====
// ----------------------------------------------------------------------------
// hfle_pkg
// Shared types, constants and table builders for the half-float
// exponential / logarithmic companding unit.
// ----------------------------------------------------------------------------
package hfle_pkg;

    localparam logic [15:0] HALF_ZERO     = 16'h0000;
    localparam logic [15:0] HALF_LARGEST  = 16'h7bff;
    localparam logic [15:0] HALF_NEG_ZERO = 16'h8000;
    localparam logic [15:0] HALF_NEG_INF  = 16'hfc00;
    localparam logic [15:0] EXP_SAT_CODE  = 16'h558c;
    localparam logic [4:0]  HALF_EXP_ALL  = 5'h1f;
    localparam logic [4:0]  EXP_FLUSH_EXP = 5'd23;

    localparam int TABLE_DEPTH = 1024;

    localparam real TABLE_STEP = 1.0 / 1024.0;
    localparam real INV_LN2    = 1.0 / 0.6931471805599453;

    // log2(e) / 8 scaled by 2^34.
    localparam logic [31:0] EXP_SCALE = 32'(longint'(1.4426950408889634 * 2147483648.0));
    // ln(2) scaled by 2^32.
    localparam logic [31:0] LN2_Q32   = 32'(longint'(0.6931471805599453 * 4294967296.0));
    // 8 * ln(2) scaled by 2^29.
    localparam logic [31:0] LOG_SCALE = 32'(longint'(5.545177444479562 * 536870912.0));

    typedef logic [31:0] rom_t [TABLE_DEPTH];

    typedef enum logic {
        OP_EXP = 1'b0,
        OP_LOG = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        spec;
        logic [15:0] sval;
    } ctl_t;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic signed [7:0] expo;
        logic [63:0]       sig;
        logic              sticky;
    } pk_t;

    // 2^(i/1024) in unsigned Q1.31.
    function automatic rom_t exp_rom_init();
        rom_t t;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            t[i] = 32'(longint'($pow(2.0, real'(i) * TABLE_STEP) * 2147483648.0));
        end
        return t;
    endfunction

    // log2(1 + i/1024) in unsigned Q0.32.
    function automatic rom_t log_rom_init();
        rom_t t;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            t[i] = 32'(longint'($ln(1.0 + real'(i) * TABLE_STEP) * INV_LN2 * 4294967296.0));
        end
        return t;
    endfunction

endpackage

// ===== design/hfle_pack.sv =====
// ----------------------------------------------------------------------------
// hfle_pack
// Rounds a normalized significand and exponent first to single precision and
// then to a binary16 word, both with round to nearest even, covering
// subnormal results, flush and overflow.
// ----------------------------------------------------------------------------
module hfle_pack import hfle_pkg::*; (
    input  pk_t         pk_i,
    output logic [15:0] half_o
);

    logic signed [7:0] ex;
    logic              normal;
    logic [6:0]        rsh;
    logic [127:0]      ext;
    logic [63:0]       q;
    logic              guard;
    logic              st;
    logic              up;
    logic [11:0]       rnd;
    logic [14:0]       base;
    logic [14:0]       mag;
    logic signed [7:0] exb;
    logic              g32;
    logic              st32;
    logic              up32;
    logic [24:0]       s25;
    logic [63:0]       sig32;

    always_comb begin
        g32  = pk_i.sig[39];
        st32 = (|pk_i.sig[38:0]) | pk_i.sticky;
        up32 = g32 & (st32 | pk_i.sig[40]);
        s25  = {1'b0, pk_i.sig[63:40]} + 25'(up32);
        if (s25[24]) begin
            sig32 = {1'b1, 63'b0};
            ex    = pk_i.expo + 8'sd1;
        end else begin
            sig32 = {s25[23:0], 40'b0};
            ex    = pk_i.expo;
        end
        normal = (ex >= -8'sd14);
        exb    = ex + 8'sd14;
        if (normal) begin
            rsh = 7'd53;
        end else if (ex < -8'sd25) begin
            rsh = 7'd65;
        end else begin
            rsh = 7'(8'sd39 - ex);
        end
        ext   = {sig32, 64'b0} >> rsh;
        q     = ext[127:64];
        guard = ext[63];
        st    = |ext[62:0];
        up    = guard & (st | q[0]);
        rnd   = 12'(q[10:0]) + 12'(up);
        base  = normal ? {exb[4:0], 10'b0} : 15'd0;
        mag   = base + 15'(rnd);
        if (pk_i.zero) begin
            half_o = {pk_i.sign, 15'd0};
        end else if (ex > 8'sd15) begin
            half_o = {pk_i.sign, 15'h7c00};
        end else begin
            half_o = {pk_i.sign, mag};
        end
    end

endmodule

// ===== design/half_float_log_exp_companding.sv =====
// An accepted input transaction passes stages A to H and the output register to m_tdata.
// Throughput: one transaction per cycle; the whole pipeline advances together,
// held only while the output register is full and m_tready is low.
// Reset (aresetn low at a clock edge) clears all valid flags; data registers keep
// their contents. No state carries from one transaction to the next.
// ----------------------------------------------------------------------------
// half_float_log_exp_companding
// Computes half(exp(v/8)) or half(8*ln(v)) for one binary16 word per cycle
// when not stalled, using table lookups in two 1024-entry ROMs, short polynomial
// correction and a two-step normalizer ahead of a shared rounding stage.
// ----------------------------------------------------------------------------
module half_float_log_exp_companding import hfle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] op
    input  logic [15:0] s_tdata,   // [15:0] half_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] half_out
);

    localparam rom_t EXP_TABLE = exp_rom_init();
    localparam rom_t LOG_TABLE = log_rom_init();

    logic        en;
    logic [7:0]  vld_reg;
    logic        out_vld_reg;
    logic [15:0] out_data_reg;
    ctl_t        ctl_reg [7];
    ctl_t        ctl_next;

    // Stage A
    op_t         a_op_reg;
    logic [15:0] a_x_reg;
    // Stage B
    logic [42:0] b_p_reg;
    logic [4:0]  b_ee_reg;
    logic        b_sgn_reg;
    logic signed [5:0] b_le_reg;
    logic [31:0] b_l_reg;
    // Stage C
    logic signed [6:0] c_n_reg;
    logic [39:0] c_f_reg;
    logic [63:0] c_cl_reg;
    logic signed [38:0] c_ce_reg;
    // Stage D
    logic [31:0] d_t_reg;
    logic [31:0] d_u_reg;
    logic signed [6:0] d_n_reg;
    logic [71:0] d_r_reg;
    // Stage E
    logic [31:0] e_t_reg;
    logic [31:0] e_u_reg;
    logic [63:0] e_usq_reg;
    logic signed [6:0] e_n_reg;
    logic        e_neg_reg;
    logic [71:0] e_a_reg;
    // Stage F
    logic [31:0] f_t_reg;
    logic [32:0] f_d_reg;
    logic signed [6:0] f_n_reg;
    logic        f_neg_reg;
    logic        f_zero_reg;
    logic [3:0]  f_kb_reg;
    logic [71:0] f_a_reg;
    // Stage G
    logic [31:0] g_t_reg;
    logic [64:0] g_prod_reg;
    logic signed [6:0] g_n_reg;
    logic        g_neg_reg;
    logic        g_zero_reg;
    logic [6:0]  g_lz_reg;
    logic [71:0] g_a_reg;
    // Stage H
    pk_t         h_pk_reg;
    pk_t         h_pk_next;
    logic [15:0] pack_half;

    // Combinational helpers
    logic [4:0]  ax_e;
    logic [9:0]  ax_m;
    logic        ax_s;
    logic [10:0] b_mant_next;
    logic [3:0]  lead_pos;
    logic [9:0]  log_addr;
    logic signed [5:0] b_le_next;
    logic [45:0] y_mag;
    logic [46:0] y_sgn;
    logic [61:0] u_prod;
    logic [3:0]  kb_next;
    logic        nz_found;
    logic [2:0]  b3_next;
    logic        b3_found;
    logic [73:0] exp_mant;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[6:0], s_tvalid};
            out_vld_reg <= vld_reg[7];
        end
    end

    // Input decode and special cases.
    always_comb begin
        ax_e = a_x_reg[14:10];
        ax_m = a_x_reg[9:0];
        ax_s = a_x_reg[15];
        ctl_next.op   = a_op_reg;
        ctl_next.spec = 1'b0;
        ctl_next.sval = HALF_ZERO;
        if (ax_e == HALF_EXP_ALL) begin
            ctl_next.spec = 1'b1;
        end else if (a_op_reg == OP_EXP) begin
            if (!ax_s && a_x_reg >= EXP_SAT_CODE) begin
                ctl_next.spec = 1'b1;
                ctl_next.sval = HALF_LARGEST;
            end else if (ax_s && ax_e >= EXP_FLUSH_EXP) begin
                ctl_next.spec = 1'b1;
            end
        end else begin
            if (a_x_reg > HALF_NEG_ZERO) begin
                ctl_next.spec = 1'b1;
            end else if (a_x_reg[14:0] == 15'd0) begin
                ctl_next.spec = 1'b1;
                ctl_next.sval = HALF_NEG_INF;
            end
        end

        b_mant_next = {(ax_e != 5'd0), ax_m};

        lead_pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (ax_m[i]) begin
                lead_pos = 4'(i);
            end
        end
        if (ax_e == 5'd0) begin
            log_addr  = 10'(ax_m << (4'd10 - lead_pos));
            b_le_next = 6'(lead_pos) - 6'sd24;
        end else begin
            log_addr  = ax_m;
            b_le_next = 6'(ax_e) - 6'sd15;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_op_reg  <= op_t'(s_tuser);
            a_x_reg   <= s_tdata;
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < 7; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            b_p_reg   <= {32'd0, b_mant_next} * {11'd0, EXP_SCALE};
            b_ee_reg  <= (ax_e == 5'd0) ? 5'd1 : ax_e;
            b_sgn_reg <= ax_s;
            b_le_reg  <= b_le_next;
            b_l_reg   <= LOG_TABLE[log_addr];
        end
    end

    // Stage C: fixed-point exponent argument, log products.
    always_comb begin
        if (b_ee_reg >= 5'd19) begin
            y_mag = 46'(b_p_reg) << (b_ee_reg - 5'd19);
        end else begin
            y_mag = 46'(b_p_reg) >> (5'd19 - b_ee_reg);
        end
        y_sgn  = b_sgn_reg ? (47'd0 - {1'b0, y_mag}) : {1'b0, y_mag};
        u_prod = 62'(c_f_reg[29:0]) * 62'(LN2_Q32);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_n_reg  <= y_sgn[46:40];
            c_f_reg  <= y_sgn[39:0];
            c_cl_reg <= {32'd0, b_l_reg} * {32'd0, LOG_SCALE};
            c_ce_reg <= 39'($signed({1'b0, LOG_SCALE})) * 39'(b_le_reg);

            d_t_reg  <= EXP_TABLE[c_f_reg[39:30]];
            d_u_reg  <= u_prod[61:30];
            d_n_reg  <= c_n_reg;
            d_r_reg  <= {c_ce_reg[38], c_ce_reg, 32'd0} + {8'd0, c_cl_reg};

            e_t_reg   <= d_t_reg;
            e_u_reg   <= d_u_reg;
            e_usq_reg <= {32'd0, d_u_reg} * {32'd0, d_u_reg};
            e_n_reg   <= d_n_reg;
            e_neg_reg <= d_r_reg[71];
            e_a_reg   <= d_r_reg[71] ? (72'd0 - d_r_reg) : d_r_reg;
        end
    end

    // Stage F and G: polynomial correction and two-step normalization.
    always_comb begin
        kb_next  = 4'd0;
        nz_found = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (!nz_found && e_a_reg[71 - 8*i -: 8] != 8'd0) begin
                kb_next  = 4'(i);
                nz_found = 1'b1;
            end
        end
        b3_next  = 3'd0;
        b3_found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!b3_found && f_a_reg[71 - i]) begin
                b3_next  = 3'(i);
                b3_found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_t_reg    <= e_t_reg;
            f_d_reg    <= 33'(e_u_reg) + 33'(e_usq_reg[63:43]);
            f_n_reg    <= e_n_reg;
            f_neg_reg  <= e_neg_reg;
            f_zero_reg <= !nz_found;
            f_kb_reg   <= kb_next;
            f_a_reg    <= e_a_reg << {kb_next, 3'b000};

            g_t_reg    <= f_t_reg;
            g_prod_reg <= 65'(f_t_reg) * 65'(f_d_reg);
            g_n_reg    <= f_n_reg;
            g_neg_reg  <= f_neg_reg;
            g_zero_reg <= f_zero_reg;
            g_lz_reg   <= {f_kb_reg, 3'b000} + 7'(b3_next);
            g_a_reg    <= f_a_reg << b3_next;
        end
    end

    // Stage H: select the path and present a normalized value for rounding.
    always_comb begin
        exp_mant = {g_t_reg, 42'd0} + 74'(g_prod_reg);
        if (ctl_reg[5].op == OP_EXP) begin
            h_pk_next.sign   = 1'b0;
            h_pk_next.zero   = 1'b0;
            h_pk_next.expo   = 8'(g_n_reg);
            h_pk_next.sig    = exp_mant[73:10];
            h_pk_next.sticky = |exp_mant[9:0];
        end else begin
            h_pk_next.sign   = g_neg_reg;
            h_pk_next.zero   = g_zero_reg;
            h_pk_next.expo   = 8'sd10 - $signed({1'b0, g_lz_reg});
            h_pk_next.sig    = g_a_reg[71:8];
            h_pk_next.sticky = |g_a_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_pk_reg     <= h_pk_next;
            out_data_reg <= ctl_reg[6].spec ? ctl_reg[6].sval : pack_half;
        end
    end

    hfle_pack u_pack (
        .pk_i   (h_pk_reg),
        .half_o (pack_half)
    );

endmodule
